[rtl/p2h_pkg.sv]
// ----------------------------------------------------------------------------
// p2h_pkg
// Shared types and constants for the pixel to hex cell unit: field widths,
// configuration register indexes and orientation coefficient magnitudes.
// ----------------------------------------------------------------------------
package p2h_pkg;

  localparam int PIX_W      = 16;
  localparam int INV_W      = 17;
  localparam int CELL_QR_W  = 13;
  localparam int CELL_S_W   = 14;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  // pixels carry 4 fraction bits, reciprocals 16
  localparam int PIX_FRAC = 4;
  localparam int INV_FRAC = 16;

  // coefficient magnitudes at 32 fraction bits
  localparam logic [63:0] K_ROOT3_32 = 64'd2479700524;
  localparam logic [63:0] K_THIRD_32 = 64'd1431655764;
  localparam logic [63:0] K_TWO3_32  = 64'd2863311532;

  localparam logic signed [CELL_QR_W-1:0] QR_MIN = {1'b1, {(CELL_QR_W-1){1'b0}}};
  localparam logic signed [CELL_QR_W-1:0] QR_MAX = {1'b0, {(CELL_QR_W-1){1'b1}}};
  localparam logic signed [CELL_S_W-1:0]  S_MIN  = {1'b1, {(CELL_S_W-1){1'b0}}};
  localparam logic signed [CELL_S_W-1:0]  S_MAX  = {1'b0, {(CELL_S_W-1){1'b1}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FLAT_TOP   = 3'd0,
    REG_ORIGIN_X   = 3'd1,
    REG_ORIGIN_Y   = 3'd2,
    REG_INV_SIZE_X = 3'd3,
    REG_INV_SIZE_Y = 3'd4
  } p2h_reg_t;

endpackage

[rtl/p2h_ifs.sv]
// ----------------------------------------------------------------------------
// p2h interfaces
// Valid/ready channels of the pixel to hex cell unit: pixel requests,
// cell results and configuration writes.
// ----------------------------------------------------------------------------
interface p2h_pixel_if import p2h_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface p2h_cell_if import p2h_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [CELL_QR_W-1:0] cell_q;
  logic signed [CELL_QR_W-1:0] cell_r;
  logic signed [CELL_S_W-1:0]  cell_s;

  modport source (output valid, cell_q, cell_r, cell_s, input ready);
  modport sink   (input valid, cell_q, cell_r, cell_s, output ready);
endinterface

interface p2h_cfg_if import p2h_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/pixel_to_hex_cell_unit.sv]
// ----------------------------------------------------------------------------
// pixel_to_hex_cell_unit
// Maps a Q12.4 pixel position to the cube coordinates of its hex cell.
// ----------------------------------------------------------------------------
// Seven-stage pipeline that takes one pixel request per clock unless back-pressure
// fills it, and returns its cell through these stages: origin subtract, reciprocal
// scale multiply, orientation matrix multiply, sum, magnitude, rounding, then cube
// fix-up and saturation into the output register. Each stage advances on its own
// so bubbles close up under back-pressure. Configuration writes are always
// ready and must land only while no request is in flight. FRAC_BITS (8..24)
// sets the coefficient precision.
module pixel_to_hex_cell_unit import p2h_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  p2h_pixel_if.sink  pixel,
  p2h_cell_if.source cube,
  p2h_cfg_if.sink    cfg
);

  localparam int NSTG = 7;
  localparam int DW   = PIX_W + 1;
  localparam int PW   = DW + INV_W + 1;
  localparam int CW   = FRAC_BITS + 1;
  localparam int MW   = PW + CW;
  localparam int FW   = MW + 2;
  localparam int TOT  = PIX_FRAC + INV_FRAC + FRAC_BITS;
  localparam int RW   = FW - TOT + 2;

  localparam logic signed [CW-1:0] C_ROOT3 =
    CW'((K_ROOT3_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic signed [CW-1:0] C_THIRD =
    CW'((K_THIRD_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic signed [CW-1:0] C_TWO3 =
    CW'((K_TWO3_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  // configuration
  logic                    flat_top;
  logic signed [PIX_W-1:0] origin_x;
  logic signed [PIX_W-1:0] origin_y;
  logic [INV_W-1:0]        inv_size_x;
  logic [INV_W-1:0]        inv_size_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_top   <= 1'b0;
      origin_x   <= '0;
      origin_y   <= '0;
      inv_size_x <= INV_W'(4096);
      inv_size_y <= INV_W'(4096);
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_FLAT_TOP:   flat_top   <= cfg.data[0];
        REG_ORIGIN_X:   origin_x   <= cfg.data[PIX_W-1:0];
        REG_ORIGIN_Y:   origin_y   <= cfg.data[PIX_W-1:0];
        REG_INV_SIZE_X: inv_size_x <= cfg.data[INV_W-1:0];
        REG_INV_SIZE_Y: inv_size_y <= cfg.data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || cube.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pixel.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= pixel.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: origin subtract
  logic signed [DW-1:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dx1 <= DW'(pixel.pixel_x) - DW'(origin_x);
      dy1 <= DW'(pixel.pixel_y) - DW'(origin_y);
    end
  end

  // stage 2: reciprocal scale
  logic signed [PW-1:0] px2, py2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      px2 <= dx1 * $signed({1'b0, inv_size_x});
      py2 <= dy1 * $signed({1'b0, inv_size_y});
    end
  end

  // stage 3: matrix products
  logic signed [CW-1:0] ca3, cc3;
  logic signed [PW-1:0] pb3;
  logic signed [MW-1:0] m0, m1, m2;

  always_comb begin
    ca3 = flat_top ? C_TWO3 : C_ROOT3;
    cc3 = flat_top ? C_ROOT3 : C_TWO3;
    pb3 = flat_top ? px2 : py2;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      m0 <= px2 * ca3;
      m1 <= pb3 * C_THIRD;
      m2 <= py2 * cc3;
    end
  end

  // stage 4: fractional q, r, s
  logic signed [FW-1:0] f4 [3];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      f4[0] <= flat_top ? FW'(m0) : FW'(m0) - FW'(m1);
      f4[1] <= flat_top ? FW'(m2) - FW'(m1) : FW'(m2);
      f4[2] <= FW'(m1) - FW'(m0) - FW'(m2);
    end
  end

  // stage 5: sign and magnitude
  logic [2:0]    neg5;
  logic [FW-1:0] mag5 [3];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        neg5[i] <= f4[i][FW-1];
        mag5[i] <= f4[i][FW-1] ? FW'(-f4[i]) : FW'(f4[i]);
      end
    end
  end

  // stage 6: round half away from zero, keep the rounding error
  logic signed [RW-1:0] int6 [3];
  logic [TOT-1:0]       err6 [3];
  logic signed [RW-1:0] rnd  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = RW'(mag5[i][FW-1:TOT]) + RW'(mag5[i][TOT-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int i = 0; i < 3; i++) begin
        int6[i] <= neg5[i] ? -rnd[i] : rnd[i];
        err6[i] <= mag5[i][TOT-1] ? (~mag5[i][TOT-1:0]) + TOT'(1) : mag5[i][TOT-1:0];
      end
    end
  end

  // stage 7: cube fix-up and saturation
  logic signed [RW-1:0]       q7, r7;
  logic signed [CELL_QR_W-1:0] q_sat, r_sat;
  logic signed [CELL_S_W:0]    s_sum;
  logic signed [CELL_QR_W-1:0] cell_q, cell_r;
  logic signed [CELL_S_W-1:0]  cell_s;

  always_comb begin
    q7 = int6[0];
    r7 = int6[1];
    if (err6[0] > err6[1] && err6[0] > err6[2]) begin
      q7 = -int6[1] - int6[2];
    end else if (err6[1] > err6[2]) begin
      r7 = -int6[0] - int6[2];
    end
    if (q7 < RW'(QR_MIN)) begin
      q_sat = QR_MIN;
    end else if (q7 > RW'(QR_MAX)) begin
      q_sat = QR_MAX;
    end else begin
      q_sat = q7[CELL_QR_W-1:0];
    end
    if (r7 < RW'(QR_MIN)) begin
      r_sat = QR_MIN;
    end else if (r7 > RW'(QR_MAX)) begin
      r_sat = QR_MAX;
    end else begin
      r_sat = r7[CELL_QR_W-1:0];
    end
    s_sum = -(CELL_S_W+1)'(q_sat) - (CELL_S_W+1)'(r_sat);
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      cell_q <= q_sat;
      cell_r <= r_sat;
      cell_s <= (s_sum > (CELL_S_W+1)'(S_MAX)) ? S_MAX : s_sum[CELL_S_W-1:0];
    end
  end

  assign cube.valid  = vld[NSTG];
  assign cube.cell_q = cell_q;
  assign cube.cell_r = cell_r;
  assign cube.cell_s = cell_s;

  // back-pressure on the input only when every stage is full and the output stalls
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> ($countones(vld) == NSTG) && !cube.ready)
    else $error("input stalled with a bubble in the pipeline");

  a_cube_sum: assert property (@(posedge clk) disable iff (rst)
    cube.valid && !(cube.cell_q == QR_MIN && cube.cell_r == QR_MIN) |->
      (CELL_S_W+1)'(cube.cell_s) ==
      -(CELL_S_W+1)'(cube.cell_q) - (CELL_S_W+1)'(cube.cell_r))
    else $error("cell_s is not minus q minus r");

  a_s_corner: assert property (@(posedge clk) disable iff (rst)
    cube.valid && cube.cell_q == QR_MIN && cube.cell_r == QR_MIN |-> cube.cell_s == S_MAX)
    else $error("cell_s corner saturation wrong");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !cube.valid)
    else $error("result valid right after reset");

endmodule

[verif/p2h_cell_checker.sv]
// ----------------------------------------------------------------------------
// p2h_cell_checker
// Watches the pixel, cell and configuration channels of the pixel to hex
// cell unit. Keeps its own copy of the layout registers, works out the cube
// cell of every accepted pixel request, and compares each returned cell
// against the oldest outstanding one.
// ----------------------------------------------------------------------------
module p2h_cell_checker import p2h_pkg::*; (
  input  logic clk,
  input  logic rst,
  p2h_pixel_if pixel_ch,
  p2h_cell_if  cell_ch,
  p2h_cfg_if   cfg_ch,
  output int   mismatches,
  output int   cells_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int TOT_FRAC  = PIX_FRAC + INV_FRAC + FRAC_BITS;

  localparam longint C_ROOT3 =
    longint'((K_ROOT3_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam longint C_THIRD =
    longint'((K_THIRD_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam longint C_TWO3 =
    longint'((K_TWO3_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  typedef struct packed {
    logic signed [PIX_W-1:0]     x;
    logic signed [PIX_W-1:0]     y;
    logic signed [CELL_QR_W-1:0] q;
    logic signed [CELL_QR_W-1:0] r;
    logic signed [CELL_S_W-1:0]  s;
  } hex_cell_t;

  logic                    flat_top;
  logic signed [PIX_W-1:0] org_x;
  logic signed [PIX_W-1:0] org_y;
  logic [INV_W-1:0]        inv_x;
  logic [INV_W-1:0]        inv_y;

  hex_cell_t cells_due[$];

  function automatic longint round_away(input longint v, output longint unsigned err);
    longint unsigned mag;
    longint unsigned m;
    longint unsigned back;
    if (v < 0) mag = -v;
    else mag = v;
    m = (mag + (64'd1 << (TOT_FRAC - 1))) >> TOT_FRAC;
    back = m << TOT_FRAC;
    err = (back >= mag) ? back - mag : mag - back;
    round_away = (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    clamp = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic hex_cell_t locate_cell(input logic signed [PIX_W-1:0] x,
                                            input logic signed [PIX_W-1:0] y);
    longint dx, dy, sx, sy, fq, fr, fs, qi, ri, si;
    longint unsigned eq, er, es;
    hex_cell_t c;
    dx = longint'(x) - longint'(org_x);
    dy = longint'(y) - longint'(org_y);
    sx = dx * longint'(inv_x);
    sy = dy * longint'(inv_y);
    if (flat_top) begin
      fq = C_TWO3 * sx;
      fr = C_ROOT3 * sy - C_THIRD * sx;
    end else begin
      fq = C_ROOT3 * sx - C_THIRD * sy;
      fr = C_TWO3 * sy;
    end
    fs = -fq - fr;
    qi = round_away(fq, eq);
    ri = round_away(fr, er);
    si = round_away(fs, es);
    // largest rounding error gets rebuilt from the other two
    if (eq > er && eq > es) qi = -ri - si;
    else if (er > es) ri = -qi - si;
    qi = clamp(qi, longint'(QR_MIN), longint'(QR_MAX));
    ri = clamp(ri, longint'(QR_MIN), longint'(QR_MAX));
    si = clamp(-qi - ri, longint'(S_MIN), longint'(S_MAX));
    c.x = x;
    c.y = y;
    c.q = qi[CELL_QR_W-1:0];
    c.r = ri[CELL_QR_W-1:0];
    c.s = si[CELL_S_W-1:0];
    locate_cell = c;
  endfunction

  always @(posedge clk) begin : watch
    hex_cell_t due;
    if (rst) begin
      flat_top = 1'b0;
      org_x = '0;
      org_y = '0;
      inv_x = INV_W'(4096);
      inv_y = INV_W'(4096);
      cells_due.delete();
      mismatches = 0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) begin
        if (cells_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected cell q=%0d r=%0d s=%0d", cell_ch.cell_q, cell_ch.cell_r,
                     cell_ch.cell_s);
        end else begin
          due = cells_due.pop_front();
          if (cell_ch.cell_q !== due.q || cell_ch.cell_r !== due.r ||
              cell_ch.cell_s !== due.s) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cell mismatch px=(%0d,%0d) exp q=%0d r=%0d s=%0d got q=%0d r=%0d s=%0d",
                       due.x, due.y, due.q, due.r, due.s,
                       cell_ch.cell_q, cell_ch.cell_r, cell_ch.cell_s);
          end
        end
      end
      if (pixel_ch.valid && pixel_ch.ready)
        cells_due.push_back(locate_cell(pixel_ch.pixel_x, pixel_ch.pixel_y));
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_FLAT_TOP:   flat_top = cfg_ch.data[0];
          REG_ORIGIN_X:   org_x = cfg_ch.data[PIX_W-1:0];
          REG_ORIGIN_Y:   org_y = cfg_ch.data[PIX_W-1:0];
          REG_INV_SIZE_X: inv_x = cfg_ch.data[INV_W-1:0];
          REG_INV_SIZE_Y: inv_y = cfg_ch.data[INV_W-1:0];
          default: ;
        endcase
      end
    end
    cells_pending = cells_due.size();
  end

endmodule

[verif/pixel_to_hex_cell_unit_test.sv]
// ----------------------------------------------------------------------------
// pixel_to_hex_cell_unit_test
// Drives pixel requests and layout register writes into the pixel to hex
// cell unit under random source gaps and sink stalls, across pointy and flat
// layouts, extreme origins and reciprocals; the checker scores every cell.
// ----------------------------------------------------------------------------
module pixel_to_hex_cell_unit_test import p2h_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_SPARSE} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   cells_pending;
  int   hold_asks = 0;
  int   quiet_cycles = 0;

  logic signed [PIX_W-1:0] cur_org_x = '0;
  logic signed [PIX_W-1:0] cur_org_y = '0;
  logic signed [PIX_W-1:0] corner_vals [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

  p2h_pixel_if pixel_ch ();
  p2h_cell_if  cell_ch ();
  p2h_cfg_if   cfg_ch ();

  pixel_to_hex_cell_unit u_top (clk, rst, pixel_ch, cell_ch, cfg_ch);

  p2h_cell_checker u_checker (clk, rst, pixel_ch, cell_ch, cfg_ch, mismatches, cells_pending);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    ready_mode_t mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    int tick;
    cell_ch.ready = 1'b0;
    mode = RDY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        cell_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS:   cell_ch.ready <= 1'b1;
          RDY_RANDOM:   cell_ch.ready <= ($urandom_range(0, 2) != 0);
          RDY_PERIODIC: cell_ch.ready <= (tick % 4 == 0);
          default:      cell_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_pixel(input logic signed [PIX_W-1:0] x,
                            input logic signed [PIX_W-1:0] y);
    @(negedge clk);
    pixel_ch.valid   <= 1'b1;
    pixel_ch.pixel_x <= x;
    pixel_ch.pixel_y <= y;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait out every outstanding request before touching the layout
  task automatic drain();
    @(negedge clk);
    pixel_ch.valid <= 1'b0;
    while (cells_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic setup(input logic flat, input logic signed [PIX_W-1:0] ox,
                       input logic signed [PIX_W-1:0] oy, input logic [INV_W-1:0] ix,
                       input logic [INV_W-1:0] iy);
    drain();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_FLAT_TOP, {16'($urandom), flat});
    write_reg(REG_ORIGIN_X, {1'($urandom), ox});
    write_reg(REG_ORIGIN_Y, {1'($urandom), oy});
    write_reg(REG_INV_SIZE_X, ix);
    write_reg(REG_INV_SIZE_Y, iy);
    cur_org_x = ox;
    cur_org_y = oy;
  endtask

  function automatic logic signed [PIX_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return corner_vals[$urandom_range(0, 3)];
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [INV_W-1:0] pick_inv();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return INV_W'(1);
      2:       return INV_W'(65536);
      3:       return '1;
      4:       return INV_W'($urandom);
      default: return INV_W'($urandom_range(256, 8192));
    endcase
  endfunction

  function automatic logic signed [PIX_W-1:0] pick_coord(input logic signed [PIX_W-1:0] o);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return PIX_W'($urandom);
      4, 5, 6, 7: return PIX_W'(o + $urandom_range(0, 2047) - 1024);
      8:          return corner_vals[$urandom_range(0, 3)];
      default:    return 16'h0001 << $urandom_range(0, PIX_W - 1);
    endcase
  endfunction

  task automatic send_corners();
    send_pixel(16'sh7FFF, 16'sh7FFF);
    send_pixel(16'sh8000, 16'sh8000);
    send_pixel(16'sh7FFF, 16'sh8000);
    send_pixel(16'sh8000, 16'sh7FFF);
  endtask

  task automatic send_run(input int count, input bit gapless);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk);
          pixel_ch.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      send_pixel(pick_coord(cur_org_x), pick_coord(cur_org_y));
    end
  endtask

  initial begin
    pixel_ch.valid   = 1'b0;
    pixel_ch.pixel_x = '0;
    pixel_ch.pixel_y = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.addr      = '0;
    cfg_ch.data      = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // registers at reset values
    send_corners();
    send_pixel(16'sh0000, 16'sh0000);
    send_pixel(16'sh0010, 16'sh0000);
    send_pixel(16'sh0008, -16'sh0008);

    // saturation: extreme origin, largest reciprocals
    setup(1'b1, 16'sh8000, 16'sh7FFF, '1, '1);
    send_corners();
    send_pixel(16'sh0000, 16'sh0000);

    // zero reciprocal on x, unit on y
    setup(1'b0, 16'sh7FFF, 16'sh8000, '0, INV_W'(65536));
    send_corners();

    // exact ties near cell centers and edges
    setup(1'b1, '0, '0, INV_W'(65536), INV_W'(65536));
    send_pixel(16'sh0008, 16'sh0000);
    send_pixel(16'sh0000, 16'sh0008);
    send_pixel(-16'sh0008, -16'sh0008);

    for (int ph = 0; ph < 12; ph++) begin
      setup(1'($urandom_range(0, 1)), pick_origin(), pick_origin(), pick_inv(), pick_inv());
      if (ph == 3) begin
        hold_asks++;
        send_run(32, 1'b1);
      end else begin
        send_run(32, ph % 4 == 1);
      end
    end

    drain();
    repeat (16) @(negedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/p2h_pkg.sv
rtl/p2h_ifs.sv
rtl/pixel_to_hex_cell_unit.sv
verif/p2h_cell_checker.sv
verif/pixel_to_hex_cell_unit_test.sv
